[rtl/hao_pkg.sv]
// ----------------------------------------------------------------------------
// hao_pkg
// Shared types, widths, reset values and the sine table generator for the
// harmonic additive oscillator bank.
// ----------------------------------------------------------------------------
package hao_pkg;

   localparam int unsigned PhaseWidth  = 32;
   localparam int unsigned StepWidth   = 31;
   localparam int unsigned CountWidth  = 5;
   localparam int unsigned GainWidth   = 16;
   localparam int unsigned IndexWidth  = 4;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned AmpWidth    = 15;

   // Sine times partial gain, then times main gain, both exact.
   localparam int unsigned Prod1Width  = 32;
   localparam int unsigned Prod2Width  = 48;
   // Rounded mix magnitude and its product with the main gain.
   localparam int unsigned Mag1Width   = 33;
   localparam int unsigned Prod3Width  = 49;

   localparam logic [StepWidth-1:0]  StepReset        = 31'd44739243;
   localparam logic [CountWidth-1:0] CountReset       = 5'd9;
   localparam logic [GainWidth-1:0]  MainGainReset    = 16'd8192;
   localparam logic [GainWidth-1:0]  PartialGainReset = 16'd8192;

   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

   typedef enum logic [1:0] {
      REG_FUNDAMENTAL_STEP = 2'd0,
      REG_ACTIVE_COUNT     = 2'd1,
      REG_MAIN_GAIN        = 2'd2
   } csr_addr_type;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SELECT,
      ST_LOOKUP,
      ST_MUL_GAIN,
      ST_MUL_MAIN,
      ST_ACCUM,
      ST_LOAD_DIV,
      ST_DIVIDE,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [StepWidth-1:0]  fundamental_step;
      logic [CountWidth-1:0] active_count;
      logic [GainWidth-1:0]  main_gain;
   } cfg_type;

   typedef struct packed {
      logic write_partial;
      logic start;
      logic fetch;
      logic lookup;
      logic mul_gain;
      logic mul_main;
      logic accum;
      logic advance;
      logic div_start;
      logic div_step;
      logic round;
      logic scale;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic part_enabled;
      logic part_last;
      logic div_done;
      logic out_free;
   } status_type;

   // One quarter-wave entry: Taylor series of sin in Q30, scaled to 15 bits.
   function automatic logic [AmpWidth-1:0] sine_entry(input int unsigned idx,
                                                      input int unsigned qbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        s;
      x    = (HalfPiQ30 * 64'(idx)) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      s = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[AmpWidth-1:0];
   endfunction

endpackage

[rtl/hao_if.sv]
// ----------------------------------------------------------------------------
// hao_if
// Request and response channel interfaces of the oscillator bank.
// ----------------------------------------------------------------------------
interface hao_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [hao_pkg::IndexWidth-1:0]      partial_index;
   logic [hao_pkg::GainWidth-1:0]       gain_value;
   logic                                enable_value;

   modport source (output valid, output kind, output partial_index,
                   output gain_value, output enable_value, input ready);
   modport sink   (input valid, input kind, input partial_index,
                   input gain_value, input enable_value, output ready);
endinterface

interface hao_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hao_pkg::SampleWidth-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/hao_csr.sv]
// ----------------------------------------------------------------------------
// hao_csr
// APB-style configuration registers: fundamental step, active count and
// main gain.
// ----------------------------------------------------------------------------
module hao_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output hao_pkg::cfg_type       cfg
);

   hao_pkg::cfg_type      cfg_ff;
   hao_pkg::csr_addr_type addr;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign addr       = hao_pkg::csr_addr_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fundamental_step <= hao_pkg::StepReset;
         cfg_ff.active_count     <= hao_pkg::CountReset;
         cfg_ff.main_gain        <= hao_pkg::MainGainReset;
      end else if (wr_en) begin
         unique case (addr)
            hao_pkg::REG_FUNDAMENTAL_STEP: begin
               cfg_ff.fundamental_step <= csr_pwdata[hao_pkg::StepWidth-1:0];
            end
            hao_pkg::REG_ACTIVE_COUNT: begin
               cfg_ff.active_count <= csr_pwdata[hao_pkg::CountWidth-1:0];
            end
            hao_pkg::REG_MAIN_GAIN: begin
               cfg_ff.main_gain <= csr_pwdata[hao_pkg::GainWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (addr)
         hao_pkg::REG_FUNDAMENTAL_STEP: begin
            csr_prdata = 32'(cfg_ff.fundamental_step);
         end
         hao_pkg::REG_ACTIVE_COUNT: begin
            csr_prdata = 32'(cfg_ff.active_count);
         end
         hao_pkg::REG_MAIN_GAIN: begin
            csr_prdata = 32'(cfg_ff.main_gain);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

[rtl/hao_ctrl.sv]
// ----------------------------------------------------------------------------
// hao_ctrl
// Sequencer of the oscillator bank: walks the active partials through the
// shared multiply path, then runs the divider, scaling and output load.
// ----------------------------------------------------------------------------
module hao_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_ready,
   input  hao_pkg::status_type   status,
   output hao_pkg::cmd_type      cmd
);

   hao_pkg::state_type state_ff;
   hao_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hao_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hao_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == hao_pkg::KIND_WRITE) begin
                  cmd.write_partial = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = hao_pkg::ST_SELECT;
               end
            end
         end
         hao_pkg::ST_SELECT: begin
            // Disabled partials only move the harmonic increment along.
            if (status.part_enabled) begin
               cmd.fetch = 1'b1;
               state_in  = hao_pkg::ST_LOOKUP;
            end else if (status.part_last) begin
               cmd.div_start = 1'b1;
               state_in      = hao_pkg::ST_DIVIDE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         hao_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = hao_pkg::ST_MUL_GAIN;
         end
         hao_pkg::ST_MUL_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = hao_pkg::ST_MUL_MAIN;
         end
         hao_pkg::ST_MUL_MAIN: begin
            cmd.mul_main = 1'b1;
            state_in     = hao_pkg::ST_ACCUM;
         end
         hao_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.part_last) begin
               state_in = hao_pkg::ST_LOAD_DIV;
            end else begin
               cmd.advance = 1'b1;
               state_in    = hao_pkg::ST_SELECT;
            end
         end
         hao_pkg::ST_LOAD_DIV: begin
            // The last product reaches the accumulator only at the end of
            // the accumulate cycle, so the divider is loaded in the cycle after it.
            cmd.div_start = 1'b1;
            state_in      = hao_pkg::ST_DIVIDE;
         end
         hao_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.round = 1'b1;
               state_in  = hao_pkg::ST_SCALE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         hao_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = hao_pkg::ST_FINISH;
         end
         hao_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = hao_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hao_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == hao_pkg::KIND_WRITE)
         |=> (state_ff == hao_pkg::ST_IDLE))
      else $error("write request did not complete in one cycle");

   a_tick_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == hao_pkg::KIND_TICK)
         |=> (state_ff == hao_pkg::ST_SELECT))
      else $error("tick request did not start the partial walk");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == hao_pkg::ST_IDLE))
      else $error("request taken outside the idle state");
`endif

endmodule

[rtl/hao_dp.sv]
// ----------------------------------------------------------------------------
// hao_dp
// Datapath of the oscillator bank: partial phase and gain memories, sine
// table, shared multiplier chain, accumulator, radix-16 divider, final
// scaling with saturation and the response register.
// ----------------------------------------------------------------------------
module hao_dp #(
   parameter int unsigned MAX_PARTIALS    = 16,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hao_pkg::cfg_type                  cfg,
   input  hao_pkg::cmd_type                  cmd,
   output hao_pkg::status_type               status,
   input  logic [hao_pkg::IndexWidth-1:0]    req_partial_index,
   input  logic [hao_pkg::GainWidth-1:0]     req_gain_value,
   input  logic                              req_enable_value,
   hao_rsp_if.source                         rsp
);

   localparam int unsigned KW    = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int unsigned NW    = $clog2(MAX_PARTIALS + 1);
   localparam int unsigned CmpW  = (hao_pkg::CountWidth > NW) ? hao_pkg::CountWidth : NW;
   localparam int unsigned IxW   = (hao_pkg::IndexWidth > NW) ? hao_pkg::IndexWidth : NW;
   localparam int unsigned AccW  = hao_pkg::Prod2Width + $clog2(MAX_PARTIALS);
   localparam int unsigned DigitBits = 4;
   localparam int unsigned DivSteps  = (AccW + DigitBits - 1) / DigitBits;
   localparam int unsigned DivW      = DivSteps * DigitBits;
   localparam int unsigned DcW       = $clog2(DivSteps + 1);
   localparam int unsigned QBits     = SINE_TABLE_BITS - 2;
   localparam int unsigned QuarterLen = 1 << QBits;
   localparam int unsigned RomAW     = QBits + 1;
   localparam int unsigned PW        = hao_pkg::PhaseWidth;
   localparam int unsigned GW        = hao_pkg::GainWidth;
   localparam int unsigned AW        = hao_pkg::AmpWidth;
   localparam int unsigned SW        = hao_pkg::SampleWidth;
   localparam int unsigned YMagW     = hao_pkg::Prod3Width + 1 - 30;

   localparam logic [DivW:0] HalfQ15 = (DivW + 1)'(1) << 14;
   localparam logic [hao_pkg::Prod3Width:0] HalfQ30 = (hao_pkg::Prod3Width + 1)'(1) << 29;

   // Quarter-wave sine table, built at elaboration.
   logic [AW-1:0] sine_rom [QuarterLen + 1];
   for (genvar i = 0; i <= QuarterLen; i++) begin : g_rom
      localparam logic [AW-1:0] Entry = hao_pkg::sine_entry(i, QBits);
      assign sine_rom[i] = Entry;
   end

   // Partial state. Valid bits stand in for the reset contents.
   logic [PW-1:0]           phase_mem_ff [MAX_PARTIALS];
   logic [GW-1:0]           gain_mem_ff  [MAX_PARTIALS];
   logic [MAX_PARTIALS-1:0] phase_valid_ff;
   logic [MAX_PARTIALS-1:0] gain_valid_ff;
   logic [MAX_PARTIALS-1:0] enable_ff;

   logic [KW-1:0]           k_ff;
   logic [NW-1:0]           n_ff;
   logic [PW-1:0]           inc_ff;
   logic [PW-1:0]           phase_rd_ff;
   logic [GW-1:0]           gain_rd_ff;
   logic [AW-1:0]           rom_ff;
   logic                    neg_ff;
   logic signed [hao_pkg::Prod1Width-1:0] prod1_ff;
   logic signed [hao_pkg::Prod2Width-1:0] prod2_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic                    sign_ff;
   logic [DivW-1:0]         quo_ff;
   logic [NW-1:0]           rem_ff;
   logic [DcW-1:0]          div_cnt_ff;
   logic [hao_pkg::Mag1Width-1:0]  mag1_ff;
   logic [hao_pkg::Prod3Width-1:0] prod3_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    sample_ff;

   logic [IxW-1:0]          wr_idx;
   logic                    wr_hit;
   logic [CmpW-1:0]         count_ext;
   logic [NW-1:0]           n_in;
   logic [SINE_TABLE_BITS-1:0] phase_top;
   logic [RomAW-1:0]        rom_addr;
   logic signed [SW-1:0]    sine_val;
   logic [AccW-1:0]         acc_abs;
   logic [DivW-1:0]         quo_in;
   logic [NW-1:0]           rem_in;
   logic [NW:0]             trial;
   logic [DivW:0]           round_sum;
   logic [hao_pkg::Prod3Width:0] y_sum;
   logic [YMagW-1:0]        y_mag;
   logic signed [SW-1:0]    sample_in;

   assign wr_idx = IxW'(req_partial_index);
   assign wr_hit = wr_idx < IxW'(MAX_PARTIALS);

   // Active count: zero acts as one, above the bank size clips to it.
   assign count_ext = CmpW'(cfg.active_count);
   always_comb begin
      if (count_ext == '0) begin
         n_in = NW'(1);
      end else if (count_ext > CmpW'(MAX_PARTIALS)) begin
         n_in = NW'(MAX_PARTIALS);
      end else begin
         n_in = count_ext[NW-1:0];
      end
   end

   // Upper phase bits: quadrant in the top two, table index below.
   assign phase_top = phase_rd_ff[PW-1 -: SINE_TABLE_BITS];
   assign rom_addr  = phase_top[SINE_TABLE_BITS-2]
                    ? (RomAW'(QuarterLen) - RomAW'(phase_top[QBits-1:0]))
                    : RomAW'(phase_top[QBits-1:0]);

   assign sine_val = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

   assign acc_abs = acc_ff[AccW-1] ? AccW'(-acc_ff) : AccW'(acc_ff);

   // Four restoring division steps per cycle on the small remainder.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int b = 0; b < DigitBits; b++) begin
         trial  = {rem_in, quo_in[DivW-1]};
         quo_in = {quo_in[DivW-2:0], 1'b0};
         if (trial >= {1'b0, n_ff}) begin
            trial     = trial - {1'b0, n_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[NW-1:0];
      end
   end

   assign round_sum = {1'b0, quo_ff} + HalfQ15;
   assign y_sum     = {1'b0, prod3_ff} + HalfQ30;
   assign y_mag     = y_sum[hao_pkg::Prod3Width -: YMagW];

   always_comb begin
      if (sign_ff) begin
         if (y_mag >= YMagW'(32768)) begin
            sample_in = {1'b1, {(SW - 1){1'b0}}};
         end else begin
            sample_in = -$signed(y_mag[SW-1:0]);
         end
      end else begin
         if (y_mag >= YMagW'(32767)) begin
            sample_in = {1'b0, {(SW - 1){1'b1}}};
         end else begin
            sample_in = $signed(y_mag[SW-1:0]);
         end
      end
   end

   // Memories: written and read in clocked blocks, read data registered.
   always_ff @(posedge clock) begin
      if (cmd.write_partial && wr_hit) begin
         gain_mem_ff[wr_idx[KW-1:0]] <= req_gain_value;
      end
      if (cmd.lookup) begin
         phase_mem_ff[k_ff] <= phase_rd_ff + inc_ff;
      end
      if (cmd.fetch) begin
         phase_rd_ff <= phase_valid_ff[k_ff] ? phase_mem_ff[k_ff] : '0;
         gain_rd_ff  <= gain_valid_ff[k_ff] ? gain_mem_ff[k_ff]
                                            : hao_pkg::PartialGainReset;
      end
      if (cmd.lookup) begin
         rom_ff <= sine_rom[rom_addr];
         neg_ff <= phase_top[SINE_TABLE_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_valid_ff <= '0;
         gain_valid_ff  <= '0;
         enable_ff      <= '1;
      end else begin
         if (cmd.write_partial && wr_hit) begin
            gain_valid_ff[wr_idx[KW-1:0]] <= 1'b1;
            enable_ff[wr_idx[KW-1:0]]     <= req_enable_value;
         end
         if (cmd.lookup) begin
            phase_valid_ff[k_ff] <= 1'b1;
         end
      end
   end

   // Partial walk and multiply chain.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         k_ff   <= '0;
         n_ff   <= n_in;
         inc_ff <= PW'(cfg.fundamental_step);
      end else if (cmd.advance) begin
         k_ff   <= k_ff + KW'(1);
         inc_ff <= inc_ff + PW'(cfg.fundamental_step);
      end
      if (cmd.mul_gain) begin
         prod1_ff <= sine_val * $signed({1'b0, gain_rd_ff});
      end
      if (cmd.mul_main) begin
         prod2_ff <= prod1_ff * $signed({1'b0, cfg.main_gain});
      end
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (cmd.accum) begin
         acc_ff <= acc_ff + AccW'(prod2_ff);
      end
      if (cmd.div_start) begin
         sign_ff <= acc_ff[AccW-1];
         quo_ff  <= DivW'(acc_abs);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
      end
      if (cmd.round) begin
         mag1_ff <= round_sum[15 +: hao_pkg::Mag1Width];
      end
      if (cmd.scale) begin
         prod3_ff <= mag1_ff * cfg.main_gain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DcW'(1);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = sample_ff;

   assign status.part_enabled = enable_ff[k_ff];
   assign status.part_last    = (NW'(k_ff) + NW'(1)) == n_ff;
   assign status.div_done     = div_cnt_ff == DcW'(DivSteps);
   assign status.out_free     = !rsp_valid_ff || rsp.ready;

`ifndef SYNTH
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp.ready))
      else $error("response overwritten before it was taken");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (acc_ff == '0))
      else $error("accumulator not cleared at tick start");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !status.div_done)
      else $error("divider stepped past its last digit");
`endif

endmodule

[rtl/harmonic_additive_oscillator_bank.sv]
// ----------------------------------------------------------------------------
// harmonic_additive_oscillator_bank
// Additive synthesis bank of harmonic sine oscillators with APB-style
// configuration and valid/ready request and response channels.
// ----------------------------------------------------------------------------
// A write request (kind 1) sets one partial's gain and enable and returns
// nothing. A tick request (kind 0) returns one sample. Once accepted, the
// tick walks the active partials through one shared multiplier chain: each
// enabled partial goes through memory read, sine lookup, gain multiply, main
// gain multiply and accumulate, and each disabled one only moves the harmonic
// increment along. When the last active partial is enabled, a separate load
// step moves the finished sum into the divider. The mix is then divided by
// the active count four quotient bits per cycle, and the result is
// rounded, scaled and loaded into the output register. The output load
// waits while the previous sample still sits untaken in the output register.
// A new request is taken while an earlier sample waits in the output register.
// Partial phases and gains sit in single-port memories whose reset contents
// come from per-entry valid bits, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module harmonic_additive_oscillator_bank #(
   parameter int unsigned MAX_PARTIALS    = 16,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic          clock,
   input  logic          reset,
   hao_req_if.sink       req_chan,
   hao_rsp_if.source     rsp_chan,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   hao_pkg::cfg_type    cfg;
   hao_pkg::cmd_type    cmd;
   hao_pkg::status_type status;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   hao_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hao_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hao_dp #(
      .MAX_PARTIALS    (MAX_PARTIALS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_partial_index (req_chan.partial_index),
      .req_gain_value    (req_chan.gain_value),
      .req_enable_value  (req_chan.enable_value),
      .rsp               (rsp_chan)
   );

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the harmonic additive oscillator bank. Tick and
// partial write requests are driven on the request channel while an
// in-bench model of the partial phases, gains and mix arithmetic predicts
// every sample. Samples are compared in order on the response channel under
// several idle, stall and register settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ClockPeriod   = 20;
   localparam int Partials      = 16;
   localparam int QuarterLen    = 256;
   localparam int SettleCycles  = 128;
   localparam int HoldOffCycles = 600;
   localparam int WatchdogLimit = 4000;
   localparam int RandomPhases  = 8;
   localparam int PhaseItems    = 200;

   localparam logic [3:0] AddrStep     = {hao_pkg::REG_FUNDAMENTAL_STEP, 2'b00};
   localparam logic [3:0] AddrCount    = {hao_pkg::REG_ACTIVE_COUNT, 2'b00};
   localparam logic [3:0] AddrMainGain = {hao_pkg::REG_MAIN_GAIN, 2'b00};
   // Register index three: nothing lives there, so writes must be dropped.
   localparam logic [3:0] AddrUnused   = 4'd12;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_op_type;

   typedef struct {
      row_op_type                     op;
      hao_pkg::kind_type              kind;
      logic [hao_pkg::IndexWidth-1:0] index;
      logic [hao_pkg::GainWidth-1:0]  gain;
      logic                           enable;
      logic [3:0]                     addr;
      logic [31:0]                    data;
      logic                           known_valid;
      logic signed [15:0]             known;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hao_req_if req_if ();
   hao_rsp_if rsp_if ();

   harmonic_additive_oscillator_bank dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Oscillator bank state as the bench sees it.
   int                             sine_quarter [0:QuarterLen];
   logic [hao_pkg::PhaseWidth-1:0] osc_phase [Partials];
   logic [hao_pkg::GainWidth-1:0]  osc_gain [Partials];
   logic                           osc_enable [Partials];
   logic [hao_pkg::StepWidth-1:0]  cur_step;
   logic [hao_pkg::CountWidth-1:0] cur_count;
   logic [hao_pkg::GainWidth-1:0]  cur_main_gain;

   logic signed [15:0] pending_samples [$];
   int                 fail_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   logic               hold_toggle = 1'b0;
   int                 quiet_cycles = 0;

   stim_row_type directed_rows [0:24] = '{
      // Every phase starts at zero, so the first sample is silent.
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b1, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_WRITE, 4'd0, 16'hFFFF, 1'b1, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_WRITE, 4'd15, 16'hFFFF, 1'b1, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrMainGain, 32'd65535, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrCount, 32'd16, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'h7FFF_FFFF, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrMainGain, 32'd0, 1'b0, 16'sd0},
      // A zero main gain silences the whole mix.
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b1, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrMainGain, 32'd32768, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrCount, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrCount, 32'd31, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrUnused, 32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_WRITE, 4'd7, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_WRITE, 4'd10, 16'h5555, 1'b1, AddrStep, 32'd0, 1'b0, 16'sd0},
      '{ROW_CSR, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd1, 1'b0, 16'sd0},
      '{ROW_REQUEST, hao_pkg::KIND_TICK, 4'd0, 16'd0, 1'b0, AddrStep, 32'd0, 1'b0, 16'sd0}
   };

   // Quarter-wave sine table: Taylor series in Q30, rounded into 15 bits.
   initial begin : build_sine_quarter
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          series;
      longint unsigned amp;
      for (int i = 0; i <= QuarterLen; i++) begin
         x      = (hao_pkg::HalfPiQ30 * longint'(i)) / QuarterLen;
         x2     = (x * x) >> 30;
         term   = x;
         series = longint'(x);
         for (int n = 1; n <= 11; n += 2) begin
            term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
            if ((((n + 1) / 2) % 2) == 1) begin
               series -= longint'(term);
            end else begin
               series += longint'(term);
            end
         end
         if (series < 0) begin
            series = 0;
         end
         amp = (longint'(series) * 32767 + (64'd1 << 29)) >> 30;
         sine_quarter[i] = (amp > 32767) ? 32767 : int'(amp);
      end
   end

   function automatic longint round_shift(input longint v, input int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v >= 0) begin
         return (v + half) >>> sh;
      end
      return -((-v + half) >>> sh);
   endfunction

   // Mixes one sample from the current phases, then advances the phases that
   // took part. Sines are read before the step is added.
   function automatic logic signed [15:0] mix_next_sample();
      longint      mix;
      longint      scaled;
      int          terms;
      int          sine;
      logic [9:0]  top;
      mix   = 0;
      terms = (cur_count == 0) ? 1 : ((cur_count > Partials) ? Partials : int'(cur_count));
      for (int k = 0; k < terms; k++) begin
         if (osc_enable[k]) begin
            top  = osc_phase[k][31:22];
            sine = top[8] ? sine_quarter[QuarterLen - int'(top[7:0])]
                          : sine_quarter[int'(top[7:0])];
            if (top[9]) begin
               sine = -sine;
            end
            mix += longint'(sine) * longint'(osc_gain[k]) * longint'(cur_main_gain);
            osc_phase[k] += 32'(k + 1) * {1'b0, cur_step};
         end
      end
      mix    = mix / longint'(terms);
      scaled = round_shift(round_shift(mix, 15) * longint'(cur_main_gain), 30);
      if (scaled > 32767) begin
         scaled = 32767;
      end
      if (scaled < -32768) begin
         scaled = -32768;
      end
      return 16'(scaled);
   endfunction

   // Offers one request with random idle cycles ahead of it, then applies it
   // to the bench state once the block takes it.
   task automatic offer_request(input hao_pkg::kind_type kind,
                                input logic [hao_pkg::IndexWidth-1:0] index,
                                input logic [hao_pkg::GainWidth-1:0] gain,
                                input logic enable,
                                input logic known_valid, input logic signed [15:0] known);
      logic signed [15:0] sample;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.kind          <= kind;
      req_if.partial_index <= index;
      req_if.gain_value    <= gain;
      req_if.enable_value  <= enable;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      if (kind == hao_pkg::KIND_WRITE) begin
         osc_gain[index]   = gain;
         osc_enable[index] = enable;
      end else begin
         sample = mix_next_sample();
         pending_samples.push_back(known_valid ? known : sample);
      end
   endtask

   // Stops sending, lets every pending sample come back, then gives the block
   // time to finish any partial write still in flight.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         AddrStep:     cur_step      = data[hao_pkg::StepWidth-1:0];
         AddrCount:    cur_count     = data[hao_pkg::CountWidth-1:0];
         AddrMainGain: cur_main_gain = data[hao_pkg::GainWidth-1:0];
         default: ;
      endcase
   endtask

   // Response side: checks each sample against the oldest prediction and
   // drives ready, including the long hold-off when asked for one.
   initial begin : sample_sink
      logic               hold_seen;
      int                 hold_left;
      logic signed [15:0] want;
      hold_seen     = 1'b0;
      hold_left     = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_samples.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected sample: expected none, actual %0d",
                        $time, rsp_if.sample_out);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_if.sample_out !== want) begin
                  fail_count++;
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, want, rsp_if.sample_out);
               end
            end
         end
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HoldOffCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0]                    step_val;
      logic [31:0]                    count_val;
      logic [31:0]                    gain_val;
      logic [hao_pkg::GainWidth-1:0]  write_gain;
      logic [hao_pkg::IndexWidth-1:0] write_index;
      req_if.valid         <= 1'b0;
      req_if.kind          <= hao_pkg::KIND_TICK;
      req_if.partial_index <= '0;
      req_if.gain_value    <= '0;
      req_if.enable_value  <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      reset                <= 1'b1;

      cur_step      = hao_pkg::StepReset;
      cur_count     = hao_pkg::CountReset;
      cur_main_gain = hao_pkg::MainGainReset;
      for (int k = 0; k < Partials; k++) begin
         osc_phase[k]  = '0;
         osc_gain[k]   = hao_pkg::PartialGainReset;
         osc_enable[k] = 1'b1;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].op == ROW_CSR) begin
            wait_idle();
            csr_write(directed_rows[r].addr, directed_rows[r].data);
         end else begin
            offer_request(directed_rows[r].kind, directed_rows[r].index,
                          directed_rows[r].gain, directed_rows[r].enable,
                          directed_rows[r].known_valid, directed_rows[r].known);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_idle();
         case ($urandom_range(3))
            0:       step_val = {1'b0, 31'($urandom)};
            1:       step_val = $urandom_range(1 << 22);
            2:       step_val = 32'h7FFF_FFFF;
            default: step_val = 32'd0;
         endcase
         case ($urandom_range(4))
            0:       count_val = $urandom_range(16, 1);
            1:       count_val = 32'd1;
            2:       count_val = 32'd16;
            3:       count_val = $urandom_range(31, 17);
            default: count_val = 32'd0;
         endcase
         case ($urandom_range(3))
            0:       gain_val = 32'd65535;
            1:       gain_val = 32'd32768;
            default: gain_val = $urandom_range(65535);
         endcase
         csr_write(AddrStep, step_val);
         csr_write(AddrCount, count_val);
         csr_write(AddrMainGain, gain_val);

         case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1:       begin send_idle_pct = 62; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct <= 62; end
            default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
         endcase
         // The response side goes quiet for a long stretch while requests
         // keep coming, so the block backs up and stalls its input.
         if (phase == 4) begin
            hold_toggle <= ~hold_toggle;
         end

         for (int n = 0; n < PhaseItems; n++) begin
            if (phase == 2 && n == PhaseItems / 2) begin
               wait_idle();
            end
            if ($urandom_range(9) < 7) begin
               offer_request(hao_pkg::KIND_TICK, hao_pkg::IndexWidth'($urandom),
                             hao_pkg::GainWidth'($urandom), 1'($urandom), 1'b0, 16'sd0);
            end else begin
               write_index = hao_pkg::IndexWidth'($urandom_range(15));
               case ($urandom_range(9))
                  0:       write_gain = '0;
                  1:       write_gain = 16'hFFFF;
                  2:       write_gain = 16'h8000;
                  default: write_gain = hao_pkg::GainWidth'($urandom_range(65535));
               endcase
               offer_request(hao_pkg::KIND_WRITE, write_index, write_gain,
                             $urandom_range(3) != 0, 1'b0, 16'sd0);
            end
         end
      end

      wait_idle();
      if (fail_count == 0 && pending_samples.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
